/* rtl/nmrc_pkg.sv */
// shared types and constants of the neighbor mode reuse cache
package nmrc_pkg;

    localparam int POS_W     = 12;
    localparam int MODE_W    = 6;
    localparam int COST_W    = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REUSE_THRESHOLD = 2'd2;

    localparam logic [POS_W-1:0]  FRAME_WIDTH_RST     = 12'd2048;
    localparam logic [POS_W-1:0]  FRAME_HEIGHT_RST    = 12'd2048;
    localparam logic [COST_W-1:0] REUSE_THRESHOLD_RST = 24'd1000;

    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        LK_LEFT     = 2'd0,
        LK_TOP      = 2'd1,
        LK_TOPLEFT  = 2'd2,
        LK_TOPRIGHT = 2'd3
    } lookup_t;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_DIVX   = 10'b00_0000_0010,
        ST_DIVY   = 10'b00_0000_0100,
        ST_COLS   = 10'b00_0000_1000,
        ST_SETUP  = 10'b00_0001_0000,
        ST_INDEX  = 10'b00_0010_0000,
        ST_READ   = 10'b00_0100_0000,
        ST_CAPT   = 10'b00_1000_0000,
        ST_WRITE  = 10'b01_0000_0000,
        ST_CLEAR  = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_payload;
        logic wr_valid;
    } grid_ctrl_t;

endpackage

/* rtl/nmrc_mac.sv */
// shared multiply-add unit with registered result
module nmrc_mac #(
    parameter int A_W = 13,
    parameter int B_W = 15,
    parameter int P_W = 30
) (
    input  logic           clk,
    input  logic           en,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    input  logic [A_W-1:0] c,
    output logic [P_W-1:0] p
);

    logic [A_W+B_W-1:0] prod;
    logic [P_W-1:0]     p_reg;
    logic [P_W-1:0]     p_next;

    always_comb
    begin
        prod   = a * b;
        p_next = P_W'(prod) + P_W'(c);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

/* rtl/nmrc_grid.sv */
// cell grid memories: mode, cost and valid bit per cell
module nmrc_grid #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                           clk,
    input  nmrc_pkg::grid_ctrl_t           ctrl,
    input  logic [AW-1:0]                  addr,
    input  logic [nmrc_pkg::MODE_W-1:0]    wr_mode,
    input  logic [nmrc_pkg::COST_W-1:0]    wr_cost,
    output logic                           rd_valid,
    output logic [nmrc_pkg::MODE_W-1:0]    rd_mode,
    output logic [nmrc_pkg::COST_W-1:0]    rd_cost
);

    logic [nmrc_pkg::MODE_W-1:0] mode_mem  [DEPTH];
    logic [nmrc_pkg::COST_W-1:0] cost_mem  [DEPTH];
    logic                        valid_mem [DEPTH];

    logic                        valid_reg;
    logic [nmrc_pkg::MODE_W-1:0] mode_reg;
    logic [nmrc_pkg::COST_W-1:0] cost_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en && ctrl.wr_payload)
        begin
            mode_mem[addr] <= wr_mode;
            cost_mem[addr] <= wr_cost;
        end
        if (ctrl.rd_en)
        begin
            mode_reg <= mode_mem[addr];
            cost_reg <= cost_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            valid_mem[addr] <= ctrl.wr_valid;
        end
        if (ctrl.rd_en)
        begin
            valid_reg <= valid_mem[addr];
        end
    end

    assign rd_valid = valid_reg;
    assign rd_mode  = mode_reg;
    assign rd_cost  = cost_reg;

endmodule

/* rtl/neighbor_mode_reuse_cache_core.sv */
// top level: sequencer, configuration registers and reuse decision
//
// channel   | transfer at edge with         | ports
// ----------+-------------------------------+--------------------------------------
// command   | start && !busy                | op pos_x pos_y mode_in cost_in
// result    | done (one cycle, no stall)    | reuse_* left_* top_* topleft_* topright_*
// config    | cfg_wr_en                     | cfg_addr cfg_wdata
//
// query: DIVX, DIVY, COLS, SETUP, then INDEX, READ, CAPT per neighbor; store: the same
// up to INDEX, then WRITE; clear sweeps all DEPTH cells (65536 at the default sizes); one
// multiply-add unit computes the quotients by block size, the grid row length and each
// cell index, then one memory read per neighbor; after reset the valid bits are swept
// to zero with busy high; results cannot be stalled; busy stays high until the result cycle is over
module neighbor_mode_reuse_cache_core #(
    parameter int MAX_FRAME_WIDTH  = 2048,
    parameter int MAX_FRAME_HEIGHT = 2048,
    parameter int BLOCK_SIZE       = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        op,
    input  logic [nmrc_pkg::POS_W-1:0]        pos_x,
    input  logic [nmrc_pkg::POS_W-1:0]        pos_y,
    input  logic [nmrc_pkg::MODE_W-1:0]       mode_in,
    input  logic [nmrc_pkg::COST_W-1:0]       cost_in,
    output logic                              done,
    output logic                              reuse_hit,
    output logic [nmrc_pkg::MODE_W-1:0]       reuse_mode,
    output logic                              left_found,
    output logic [nmrc_pkg::MODE_W-1:0]       left_mode,
    output logic [nmrc_pkg::COST_W-1:0]       left_cost,
    output logic                              top_found,
    output logic [nmrc_pkg::MODE_W-1:0]       top_mode,
    output logic [nmrc_pkg::COST_W-1:0]       top_cost,
    output logic                              topleft_found,
    output logic [nmrc_pkg::MODE_W-1:0]       topleft_mode,
    output logic                              topright_found,
    output logic [nmrc_pkg::MODE_W-1:0]       topright_mode,
    input  logic                              cfg_wr_en,
    input  logic [nmrc_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [nmrc_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int GRID_COLS_MAX = (MAX_FRAME_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int GRID_ROWS_MAX = (MAX_FRAME_HEIGHT + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int DEPTH         = GRID_COLS_MAX * GRID_ROWS_MAX;
    localparam int AW            = $clog2(DEPTH);
    localparam int BLK_L         = $clog2(BLOCK_SIZE);
    localparam int DIV_W         = $clog2((1 << nmrc_pkg::POS_W) + BLOCK_SIZE);
    localparam int SHIFT         = DIV_W + BLK_L;
    localparam int RECIP         = ((1 << SHIFT) + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int M_W           = DIV_W + 2;
    localparam int P_W           = SHIFT + DIV_W + 1;

    localparam logic [DIV_W-1:0] BLK     = DIV_W'(BLOCK_SIZE);
    localparam logic [DIV_W-1:0] BLK_M1  = DIV_W'(BLOCK_SIZE - 1);
    localparam logic [DIV_W-1:0] ONE     = DIV_W'(1);
    localparam logic [M_W-1:0]   RECIP_M = M_W'(RECIP);
    localparam logic [P_W-1:0]   DEPTH_P = P_W'(DEPTH);
    localparam logic [AW-1:0]    LAST    = AW'(DEPTH - 1);

    nmrc_pkg::state_t  state_reg, state_next;
    nmrc_pkg::lookup_t lk_reg, lk_next;
    logic [AW-1:0]     sweep_reg, sweep_next;

    logic [nmrc_pkg::POS_W-1:0]  width_reg, height_reg;
    logic [nmrc_pkg::COST_W-1:0] thresh_reg;

    logic [1:0]                  op_reg;
    logic [nmrc_pkg::POS_W-1:0]  x_reg, y_reg;
    logic [nmrc_pkg::MODE_W-1:0] mode_reg;
    logic [nmrc_pkg::COST_W-1:0] cost_reg;

    logic [DIV_W-1:0] qx_reg, qy_reg, cols_reg;
    logic             ok_reg;

    logic                        found_reg [4];
    logic [nmrc_pkg::MODE_W-1:0] fmode_reg [4];
    logic [nmrc_pkg::COST_W-1:0] lcost_reg, tcost_reg;

    logic             mac_en;
    logic [DIV_W-1:0] mac_a, mac_c;
    logic [M_W-1:0]   mac_b;
    logic [P_W-1:0]   mac_p;
    logic [DIV_W-1:0] quot;

    nmrc_pkg::grid_ctrl_t        gctrl;
    logic [AW-1:0]               gaddr;
    logic                        g_valid;
    logic [nmrc_pkg::MODE_W-1:0] g_mode;
    logic [nmrc_pkg::COST_W-1:0] g_cost;

    logic [DIV_W-1:0] xw, yw, fw, fh;
    logic             x_ge, x_in, xm_in, xp_in, y_ge, y_in, ym_in;
    logic             lk_ok, in_range, is_query, found_now;
    logic [DIV_W-1:0] row_sel, col_sel;
    logic [nmrc_pkg::COST_W-1:0] half;

    logic             done_reg;
    logic             accept;

    assign accept = start && !busy;

    assign xw = DIV_W'(x_reg);
    assign yw = DIV_W'(y_reg);
    assign fw = DIV_W'(width_reg);
    assign fh = DIV_W'(height_reg);

    // frame bounds of the neighbor positions
    always_comb
    begin
        x_ge  = xw >= BLK;
        x_in  = xw < fw;
        xm_in = x_ge && ((xw - BLK) < fw);
        xp_in = (xw + BLK) < fw;
        y_ge  = yw >= BLK;
        y_in  = yw < fh;
        ym_in = y_ge && ((yw - BLK) < fh);
    end

    assign is_query = op_reg == nmrc_pkg::OP_QUERY;
    assign quot     = mac_p[SHIFT +: DIV_W];
    assign in_range = mac_p < DEPTH_P;

    always_comb
    begin
        row_sel = qy_reg - ONE;
        col_sel = qx_reg;
        lk_ok   = 1'b0;
        if (!is_query)
        begin
            row_sel = qy_reg;
            lk_ok   = x_in && y_in;
        end
        else
        begin
            case (lk_reg)
                nmrc_pkg::LK_LEFT:
                begin
                    row_sel = qy_reg;
                    col_sel = qx_reg - ONE;
                    lk_ok   = xm_in && y_in;
                end
                nmrc_pkg::LK_TOP:
                begin
                    lk_ok = x_in && ym_in;
                end
                nmrc_pkg::LK_TOPLEFT:
                begin
                    col_sel = qx_reg - ONE;
                    lk_ok   = xm_in && ym_in;
                end
                nmrc_pkg::LK_TOPRIGHT:
                begin
                    col_sel = qx_reg + ONE;
                    lk_ok   = xp_in && ym_in;
                end
                default:
                begin
                    lk_ok = 1'b0;
                end
            endcase
        end
    end

    // shared unit operands
    always_comb
    begin
        mac_en = 1'b1;
        mac_a  = xw;
        mac_b  = RECIP_M;
        mac_c  = '0;
        case (state_reg)
            nmrc_pkg::ST_DIVX:
            begin
                mac_a = xw;
            end
            nmrc_pkg::ST_DIVY:
            begin
                mac_a = yw;
            end
            nmrc_pkg::ST_COLS:
            begin
                mac_a = fw + BLK_M1;
            end
            nmrc_pkg::ST_INDEX:
            begin
                mac_a = row_sel;
                mac_b = M_W'(cols_reg);
                mac_c = col_sel;
            end
            default:
            begin
                mac_en = 1'b0;
            end
        endcase
    end

    nmrc_mac #(
        .A_W (DIV_W),
        .B_W (M_W),
        .P_W (P_W)
    ) u_mac (
        .clk (clk),
        .en  (mac_en),
        .a   (mac_a),
        .b   (mac_b),
        .c   (mac_c),
        .p   (mac_p)
    );

    always_comb
    begin
        gctrl.rd_en      = state_reg == nmrc_pkg::ST_READ;
        gctrl.wr_en      = 1'b0;
        gctrl.wr_payload = 1'b0;
        gctrl.wr_valid   = 1'b0;
        gaddr            = mac_p[AW-1:0];
        if (state_reg == nmrc_pkg::ST_CLEAR)
        begin
            gctrl.wr_en = 1'b1;
            gaddr       = sweep_reg;
        end
        else if (state_reg == nmrc_pkg::ST_WRITE)
        begin
            gctrl.wr_en      = ok_reg && in_range;
            gctrl.wr_payload = 1'b1;
            gctrl.wr_valid   = 1'b1;
        end
    end

    nmrc_grid #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_grid (
        .clk      (clk),
        .ctrl     (gctrl),
        .addr     (gaddr),
        .wr_mode  (mode_reg),
        .wr_cost  (cost_reg),
        .rd_valid (g_valid),
        .rd_mode  (g_mode),
        .rd_cost  (g_cost)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        lk_next    = lk_reg;
        sweep_next = sweep_reg;
        case (state_reg)
            nmrc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        nmrc_pkg::OP_STORE, nmrc_pkg::OP_QUERY:
                        begin
                            state_next = nmrc_pkg::ST_DIVX;
                        end
                        nmrc_pkg::OP_CLEAR:
                        begin
                            state_next = nmrc_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = nmrc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            nmrc_pkg::ST_DIVX:
            begin
                state_next = nmrc_pkg::ST_DIVY;
            end
            nmrc_pkg::ST_DIVY:
            begin
                state_next = nmrc_pkg::ST_COLS;
            end
            nmrc_pkg::ST_COLS:
            begin
                state_next = nmrc_pkg::ST_SETUP;
            end
            nmrc_pkg::ST_SETUP:
            begin
                lk_next    = nmrc_pkg::LK_LEFT;
                state_next = nmrc_pkg::ST_INDEX;
            end
            nmrc_pkg::ST_INDEX:
            begin
                state_next = is_query ? nmrc_pkg::ST_READ : nmrc_pkg::ST_WRITE;
            end
            nmrc_pkg::ST_READ:
            begin
                state_next = nmrc_pkg::ST_CAPT;
            end
            nmrc_pkg::ST_CAPT:
            begin
                if (lk_reg == nmrc_pkg::LK_TOPRIGHT)
                begin
                    state_next = nmrc_pkg::ST_IDLE;
                end
                else
                begin
                    lk_next    = nmrc_pkg::lookup_t'(lk_reg + 2'd1);
                    state_next = nmrc_pkg::ST_INDEX;
                end
            end
            nmrc_pkg::ST_WRITE:
            begin
                state_next = nmrc_pkg::ST_IDLE;
            end
            nmrc_pkg::ST_CLEAR:
            begin
                if (sweep_reg == LAST)
                begin
                    sweep_next = '0;
                    state_next = nmrc_pkg::ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = nmrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nmrc_pkg::ST_CLEAR;
            lk_reg    <= nmrc_pkg::LK_LEFT;
            sweep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lk_reg    <= lk_next;
            sweep_reg <= sweep_next;
        end
    end

    // result strobe: registered, high in the cycle after the CAPT state of the last neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == nmrc_pkg::ST_CAPT) && (lk_reg == nmrc_pkg::LK_TOPRIGHT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= nmrc_pkg::FRAME_WIDTH_RST;
            height_reg <= nmrc_pkg::FRAME_HEIGHT_RST;
            thresh_reg <= nmrc_pkg::REUSE_THRESHOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                nmrc_pkg::CFG_FRAME_WIDTH:
                begin
                    width_reg <= cfg_wdata[nmrc_pkg::POS_W-1:0];
                end
                nmrc_pkg::CFG_FRAME_HEIGHT:
                begin
                    height_reg <= cfg_wdata[nmrc_pkg::POS_W-1:0];
                end
                nmrc_pkg::CFG_REUSE_THRESHOLD:
                begin
                    thresh_reg <= cfg_wdata[nmrc_pkg::COST_W-1:0];
                end
                default:
                begin
                    thresh_reg <= thresh_reg;
                end
            endcase
        end
    end

    assign found_now = ok_reg && g_valid;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            x_reg    <= pos_x;
            y_reg    <= pos_y;
            mode_reg <= mode_in;
            cost_reg <= cost_in;
        end
        if (state_reg == nmrc_pkg::ST_DIVY)
        begin
            qx_reg <= quot;
        end
        if (state_reg == nmrc_pkg::ST_COLS)
        begin
            qy_reg <= quot;
        end
        if (state_reg == nmrc_pkg::ST_SETUP)
        begin
            cols_reg <= quot;
        end
        if (state_reg == nmrc_pkg::ST_INDEX)
        begin
            ok_reg <= lk_ok;
        end
        if (state_reg == nmrc_pkg::ST_READ)
        begin
            ok_reg <= ok_reg && in_range;
        end
        if (state_reg == nmrc_pkg::ST_CAPT)
        begin
            found_reg[lk_reg] <= found_now;
            fmode_reg[lk_reg] <= found_now ? g_mode : '0;
            if (lk_reg == nmrc_pkg::LK_LEFT)
            begin
                lcost_reg <= found_now ? g_cost : '0;
            end
            if (lk_reg == nmrc_pkg::LK_TOP)
            begin
                tcost_reg <= found_now ? g_cost : '0;
            end
        end
    end

    // reuse decision
    assign half = thresh_reg >> 1;

    always_comb
    begin
        reuse_hit  = 1'b0;
        reuse_mode = '0;
        if (found_reg[nmrc_pkg::LK_LEFT] && found_reg[nmrc_pkg::LK_TOP]
            && (fmode_reg[nmrc_pkg::LK_LEFT] == fmode_reg[nmrc_pkg::LK_TOP])
            && (lcost_reg < thresh_reg) && (tcost_reg < thresh_reg))
        begin
            reuse_hit  = 1'b1;
            reuse_mode = fmode_reg[nmrc_pkg::LK_LEFT];
        end
        else if (found_reg[nmrc_pkg::LK_LEFT] && (lcost_reg < half))
        begin
            reuse_hit  = 1'b1;
            reuse_mode = fmode_reg[nmrc_pkg::LK_LEFT];
        end
        else if (found_reg[nmrc_pkg::LK_TOP] && (tcost_reg < half))
        begin
            reuse_hit  = 1'b1;
            reuse_mode = fmode_reg[nmrc_pkg::LK_TOP];
        end
    end

    assign busy           = (state_reg != nmrc_pkg::ST_IDLE) || done_reg;
    assign done           = done_reg;
    assign left_found     = found_reg[nmrc_pkg::LK_LEFT];
    assign left_mode      = fmode_reg[nmrc_pkg::LK_LEFT];
    assign left_cost      = lcost_reg;
    assign top_found      = found_reg[nmrc_pkg::LK_TOP];
    assign top_mode       = fmode_reg[nmrc_pkg::LK_TOP];
    assign top_cost       = tcost_reg;
    assign topleft_found  = found_reg[nmrc_pkg::LK_TOPLEFT];
    assign topleft_mode   = fmode_reg[nmrc_pkg::LK_TOPLEFT];
    assign topright_found = found_reg[nmrc_pkg::LK_TOPRIGHT];
    assign topright_mode  = fmode_reg[nmrc_pkg::LK_TOPRIGHT];

endmodule
